// ===== hdl/cmsp_pkg.sv =====
// Package for the CoAP message stream parser.
// Types, codes and constants shared by the front end, queue and back end.
package cmsp_pkg;

   typedef enum logic [2:0] {
      PH_HEADER, PH_TOKEN, PH_OPTHEAD, PH_DELTAEXT,
      PH_LENEXT, PH_VALUE, PH_PAYLOAD, PH_HALT
   } phase_type;

   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_TOKEN   = 3'd1;
   localparam logic [2:0] KIND_OPTION  = 3'd2;
   localparam logic [2:0] KIND_VALUE   = 3'd3;
   localparam logic [2:0] KIND_PAYLOAD = 3'd4;
   localparam logic [2:0] KIND_END     = 3'd5;

   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_TRUNC     = 4'd1;
   localparam logic [3:0] ST_VERSION   = 4'd2;
   localparam logic [3:0] ST_TOKEN     = 4'd3;
   localparam logic [3:0] ST_CLASS     = 4'd4;
   localparam logic [3:0] ST_NIBBLE    = 4'd5;
   localparam logic [3:0] ST_EMPTY_PL  = 4'd6;
   localparam logic [3:0] ST_BAD_EMPTY = 4'd7;
   localparam logic [3:0] ST_RESET_MSG = 4'd8;
   localparam logic [3:0] ST_OVERFLOW  = 4'd9;

   localparam logic [1:0] TYPE_NON = 2'd1;
   localparam logic [1:0] TYPE_RST = 2'd3;

   localparam logic [0:0] REG_VERSION = 1'd0;
   localparam logic [0:0] REG_MAX_TKL = 1'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  byte_out;
      logic [1:0]  msg_type;
      logic [3:0]  token_count;
      logic [2:0]  class_bits;
      logic [4:0]  detail_bits;
      logic [15:0] message_id;
      logic [15:0] option_number;
      logic [16:0] option_length;
      logic [3:0]  status;
      logic        end_of_run;
   } result_type;

   // one queue entry: up to two results that one byte causes
   typedef struct packed {
      logic       two;
      result_type first;
      result_type second;
   } entry_type;

endpackage

// ===== hdl/cmsp_front.sv =====
// Front end: takes datagram words, tracks parse state, builds result entries.
// Depends on cmsp_pkg.
module cmsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          expected_version,
   input  logic [3:0]          max_token_length,
   input  logic                in_valid,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   output logic                in_ready,
   output logic                ent_valid,
   output cmsp_pkg::entry_type ent,
   input  logic                ent_ready
);
   import cmsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hidx_ff, hidx_in;
   logic [1:0]  type_ff, type_in;
   logic [3:0]  tkl_ff, tkl_in;
   logic [2:0]  cls_ff, cls_in;
   logic [4:0]  det_ff, det_in;
   logic [15:0] id_ff, id_in;
   logic [3:0]  tleft_ff, tleft_in;
   logic [15:0] prev_ff, prev_in;
   logic [16:0] pdelta_ff, pdelta_in;
   logic [16:0] plen_ff, plen_in;
   logic [1:0]  ext_ff, ext_in;
   logic [16:0] vleft_ff, vleft_in;
   logic        sopt_ff, sopt_in;
   logic        spay_ff, spay_in;
   logic [3:0]  err_ff, err_in;

   logic        fire;
   logic        e_valid;
   result_type  r0, r1;
   logic        n0, n1;

   assign in_ready  = ent_ready;
   assign fire      = in_valid & in_ready;
   assign ent_valid = fire & e_valid;

   always_comb begin
      logic [3:0]  dn, ln;
      logic [17:0] sum;
      logic [16:0] acc;
      logic        do_finish, do_len;
      logic [3:0]  st;
      result_type  base, ro;
      phase_in = phase_ff; hidx_in = hidx_ff; type_in = type_ff; tkl_in = tkl_ff;
      cls_in = cls_ff; det_in = det_ff; id_in = id_ff; tleft_in = tleft_ff;
      prev_in = prev_ff; pdelta_in = pdelta_ff; plen_in = plen_ff; ext_in = ext_ff;
      vleft_in = vleft_ff; sopt_in = sopt_ff; spay_in = spay_ff; err_in = err_ff;
      dn = data_byte[7:4]; ln = data_byte[3:0];
      do_finish = 1'b0; do_len = 1'b0; sum = '0; acc = '0; st = ST_OK;
      n0 = 1'b0; n1 = 1'b0;
      ro = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hidx_ff == 2'd0) begin
               type_in = data_byte[5:4];
               tkl_in  = data_byte[3:0];
               if (data_byte[7:6] != expected_version) begin
                  err_in = ST_VERSION; phase_in = PH_HALT;
               end else if (data_byte[3:0] > max_token_length) begin
                  err_in = ST_TOKEN; phase_in = PH_HALT;
               end
            end else if (hidx_ff == 2'd1) begin
               cls_in = data_byte[7:5];
               det_in = data_byte[4:0];
               if (!(data_byte[7:5] == 3'd0 || data_byte[7:5] == 3'd2 ||
                     data_byte[7:5] == 3'd4 || data_byte[7:5] == 3'd5)) begin
                  err_in = ST_CLASS; phase_in = PH_HALT;
               end
            end else if (hidx_ff == 2'd2) begin
               id_in = {data_byte, 8'd0};
            end else begin
               id_in = {id_ff[15:8], data_byte};
               n0 = 1'b1; ro.kind = KIND_HEADER;
               tleft_in = tkl_ff;
               phase_in = (tkl_ff != 4'd0) ? PH_TOKEN : PH_OPTHEAD;
            end
            hidx_in = hidx_ff + 2'd1;
         end
         PH_TOKEN: begin
            n0 = 1'b1; ro.kind = KIND_TOKEN; ro.byte_out = data_byte;
            tleft_in = tleft_ff - 4'd1;
            if (tleft_ff == 4'd1) phase_in = PH_OPTHEAD;
         end
         PH_OPTHEAD: begin
            if (data_byte == 8'hff) begin
               phase_in = PH_PAYLOAD;
            end else if (dn == 4'd15 || ln == 4'd15) begin
               err_in = ST_NIBBLE; phase_in = PH_HALT;
            end else begin
               plen_in = {13'd0, ln};
               if (dn == 4'd13) begin
                  pdelta_in = 17'd13; ext_in = 2'd1; phase_in = PH_DELTAEXT;
               end else if (dn == 4'd14) begin
                  pdelta_in = 17'd269; ext_in = 2'd2; phase_in = PH_DELTAEXT;
               end else begin
                  pdelta_in = {13'd0, dn};
                  do_len = 1'b1;
               end
            end
         end
         PH_DELTAEXT: begin
            acc = (ext_ff == 2'd2) ? pdelta_ff + {1'b0, data_byte, 8'd0}
                                   : pdelta_ff + {9'd0, data_byte};
            pdelta_in = acc;
            ext_in = ext_ff - 2'd1;
            if (ext_ff == 2'd1) do_len = 1'b1;
         end
         PH_LENEXT: begin
            acc = (ext_ff == 2'd2) ? plen_ff + {1'b0, data_byte, 8'd0}
                                   : plen_ff + {9'd0, data_byte};
            plen_in = acc;
            ext_in = ext_ff - 2'd1;
            if (ext_ff == 2'd1) do_finish = 1'b1;
         end
         PH_VALUE: begin
            n0 = 1'b1; ro.kind = KIND_VALUE; ro.byte_out = data_byte;
            vleft_in = vleft_ff - 17'd1;
            if (vleft_ff == 17'd1) phase_in = PH_OPTHEAD;
         end
         PH_PAYLOAD: begin
            n0 = 1'b1; ro.kind = KIND_PAYLOAD; ro.byte_out = data_byte;
            spay_in = 1'b1;
         end
         default: begin
         end
      endcase
      if (do_len) begin
         if (plen_in == 17'd13) begin
            ext_in = 2'd1; phase_in = PH_LENEXT;
         end else if (plen_in == 17'd14) begin
            plen_in = 17'd269; ext_in = 2'd2; phase_in = PH_LENEXT;
         end else begin
            do_finish = 1'b1;
         end
      end
      if (do_finish) begin
         sum = {2'b0, prev_ff} + {1'b0, pdelta_in};
         if (sum[17:16] != 2'b00) begin
            if (err_in == ST_OK) err_in = ST_OVERFLOW;
            phase_in = PH_HALT;
         end else begin
            n0 = 1'b1; ro.kind = KIND_OPTION;
            ro.option_number = sum[15:0]; ro.option_length = plen_in;
            prev_in = sum[15:0]; sopt_in = 1'b1;
            if (plen_in != 17'd0) begin
               vleft_in = plen_in; phase_in = PH_VALUE;
            end else begin
               phase_in = PH_OPTHEAD;
            end
         end
      end
      base = '0;
      base.msg_type = type_in; base.token_count = tkl_in; base.class_bits = cls_in;
      base.detail_bits = det_in; base.message_id = id_in;
      r0 = ro;
      r0.msg_type = type_in; r0.token_count = tkl_in; r0.class_bits = cls_in;
      r0.detail_bits = det_in; r0.message_id = id_in;
      if (err_in != ST_OK) st = err_in;
      else if (phase_in == PH_PAYLOAD && !spay_in) st = ST_EMPTY_PL;
      else if (phase_in != PH_OPTHEAD && phase_in != PH_PAYLOAD) st = ST_TRUNC;
      else if (cls_in == 3'd0 && det_in == 5'd0) begin
         if (type_in == TYPE_NON || tkl_in != 4'd0 || sopt_in || spay_in)
            st = ST_BAD_EMPTY;
      end else if (type_in == TYPE_RST) st = ST_RESET_MSG;
      r1 = base; r1.kind = KIND_END; r1.status = st; r1.end_of_run = 1'b1;
      n1 = last_byte;
      if (last_byte) begin
         phase_in = PH_HEADER; hidx_in = '0; type_in = '0; tkl_in = '0;
         cls_in = '0; det_in = '0; id_in = '0; tleft_in = '0; prev_in = '0;
         pdelta_in = '0; plen_in = '0; ext_in = '0; vleft_in = '0;
         sopt_in = 1'b0; spay_in = 1'b0; err_in = ST_OK;
      end
   end

   always_comb begin
      result_type lead;
      lead = r0;
      if (!n1) lead.end_of_run = 1'b1;
      e_valid = n0 | n1;
      ent.two = n0 & n1;
      ent.first = n0 ? lead : r1;
      ent.second = r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; hidx_ff <= '0; type_ff <= '0; tkl_ff <= '0;
         cls_ff <= '0; det_ff <= '0; id_ff <= '0; tleft_ff <= '0; prev_ff <= '0;
         pdelta_ff <= '0; plen_ff <= '0; ext_ff <= '0; vleft_ff <= '0;
         sopt_ff <= 1'b0; spay_ff <= 1'b0; err_ff <= ST_OK;
      end else if (fire) begin
         phase_ff <= phase_in; hidx_ff <= hidx_in; type_ff <= type_in; tkl_ff <= tkl_in;
         cls_ff <= cls_in; det_ff <= det_in; id_ff <= id_in; tleft_ff <= tleft_in;
         prev_ff <= prev_in; pdelta_ff <= pdelta_in; plen_ff <= plen_in;
         ext_ff <= ext_in; vleft_ff <= vleft_in; sopt_ff <= sopt_in;
         spay_ff <= spay_in; err_ff <= err_in;
      end
   end
endmodule

// ===== hdl/cmsp_queue.sv =====
// Short queue of result entries between front end and back end.
// Depends on cmsp_pkg.
module cmsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   input  cmsp_pkg::entry_type wr_data,
   output logic                wr_ready,
   output logic                rd_valid,
   output cmsp_pkg::entry_type rd_data,
   input  logic                rd_pop
);
   import cmsp_pkg::*;

   entry_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QUEUE_AW:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign wr_ready = (cnt_ff != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid & wr_ready;
   assign pop      = rd_pop & rd_valid;

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + {{QUEUE_AW{1'b0}}, push} - {{QUEUE_AW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== hdl/cmsp_back.sv =====
// Back end: unpacks queue entries into single results on the output channel.
// Depends on cmsp_pkg.
module cmsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  cmsp_pkg::entry_type  q_data,
   output logic                 q_pop,
   output logic                 out_valid,
   output cmsp_pkg::result_type out_data,
   input  logic                 out_ready
);
   import cmsp_pkg::*;

   logic sec_ff, sec_in;
   logic take;

   assign out_valid = q_valid;
   assign out_data  = sec_ff ? q_data.second : q_data.first;
   assign take      = out_valid & out_ready;
   assign q_pop     = take & (sec_ff | ~q_data.two);

   always_comb begin
      sec_in = sec_ff;
      if (take) sec_in = ~sec_ff & q_data.two;
   end

   always_ff @(posedge clock) begin
      if (reset) sec_ff <= 1'b0;
      else sec_ff <= sec_in;
   end
endmodule

// ===== hdl/coap_message_stream_parser.sv =====
// Top level of the CoAP message stream parser: CSR port, front end, queue, back end.
// Depends on cmsp_pkg, cmsp_front, cmsp_queue, cmsp_back.
//
// channel  ports              direction  role
// req      req_valid/ready    in         datagram word and last flag
// rsp      rsp_valid/ready    out        up to two results per word, one per cycle when rsp_ready
// csr      psel..pready       in/out     version and max token length
//
// One word per cycle when rsp keeps up; the results of a word are written into the
// queue when the word is accepted and leave it in order. A word causing two results
// holds its queue entry while the back end sends them in turn.
// A 4-entry queue decouples front and back; req_ready drops when it is full.
// Reset is synchronous; it clears parse state and sets registers to 1 and 8.
module coap_message_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_byte_out,
   output logic [1:0]  rsp_msg_type,
   output logic [3:0]  rsp_token_count,
   output logic [2:0]  rsp_class_bits,
   output logic [4:0]  rsp_detail_bits,
   output logic [15:0] rsp_message_id,
   output logic [15:0] rsp_option_number,
   output logic [16:0] rsp_option_length,
   output logic [3:0]  rsp_status,
   output logic        rsp_end_of_run,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import cmsp_pkg::*;

   logic [1:0] ver_ff;
   logic [3:0] mtk_ff;
   logic       wr;
   logic       ent_valid, ent_ready, q_valid, q_pop;
   entry_type  ent, q_data;
   result_type res;

   assign pready = 1'b1;
   assign wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ver_ff <= 2'd1; mtk_ff <= 4'd8;
      end else if (wr) begin
         if (paddr[2] == REG_VERSION) ver_ff <= pwdata[1:0];
         else mtk_ff <= pwdata[3:0];
      end
   end

   always_comb begin
      prdata = '0;
      case (paddr[2])
         REG_VERSION: prdata = {30'd0, ver_ff};
         default:     prdata = {28'd0, mtk_ff};
      endcase
   end

   cmsp_front u_front (
      .clock, .reset, .expected_version(ver_ff), .max_token_length(mtk_ff),
      .in_valid(req_valid), .data_byte(req_data_byte), .last_byte(req_last_byte),
      .in_ready(req_ready), .ent_valid, .ent, .ent_ready
   );

   cmsp_queue u_queue (
      .clock, .reset, .wr_valid(ent_valid), .wr_data(ent), .wr_ready(ent_ready),
      .rd_valid(q_valid), .rd_data(q_data), .rd_pop(q_pop)
   );

   cmsp_back u_back (
      .clock, .reset, .q_valid, .q_data, .q_pop,
      .out_valid(rsp_valid), .out_data(res), .out_ready(rsp_ready)
   );

   assign rsp_kind          = res.kind;
   assign rsp_byte_out      = res.byte_out;
   assign rsp_msg_type      = res.msg_type;
   assign rsp_token_count   = res.token_count;
   assign rsp_class_bits    = res.class_bits;
   assign rsp_detail_bits   = res.detail_bits;
   assign rsp_message_id    = res.message_id;
   assign rsp_option_number = res.option_number;
   assign rsp_option_length = res.option_length;
   assign rsp_status        = res.status;
   assign rsp_end_of_run    = res.end_of_run;

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_kind <= KIND_END) else $error("bad result kind");
   a_end_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_END) |-> rsp_end_of_run)
      else $error("end status without end of run");
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_END) |-> rsp_status == ST_OK)
      else $error("status on non-end result");
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (ent_valid && !ent_ready) |-> 1'b0) else $error("entry pushed into full queue");
endmodule

// ===== bench/cmsp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the CoAP message stream parser: watches req, rsp and CSR writes,
// predicts the results of each accepted word and compares them in order.
// Depends on cmsp_pkg.
module cmsp_checker
   import cmsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  result_type  rsp_word,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          mismatches,
   output int          pending
);

   localparam logic [2:0] ADDR_VERSION = 3'(REG_VERSION) << 2;
   localparam logic [2:0] ADDR_MAX_TKL = 3'(REG_MAX_TKL) << 2;

   result_type expected_results[$];
   result_type word_results[$];

   logic [1:0]  cfg_version;
   logic [3:0]  cfg_max_tkl;
   phase_type   parse_phase;
   logic [1:0]  hdr_index, hdr_type;
   logic [3:0]  hdr_tkl, token_left;
   logic [2:0]  hdr_class;
   logic [4:0]  hdr_detail;
   logic [15:0] hdr_id, prev_number;
   int          delta_acc, length_acc, ext_left, value_left;
   bit          seen_option, seen_payload;
   logic [3:0]  first_error;

   assign pending = expected_results.size();

   task automatic clear_datagram();
      parse_phase = PH_HEADER;
      hdr_index = '0; hdr_type = '0; hdr_tkl = '0; hdr_class = '0; hdr_detail = '0;
      hdr_id = '0; token_left = '0; prev_number = '0; delta_acc = 0; length_acc = 0;
      ext_left = 0; value_left = 0; seen_option = 0; seen_payload = 0;
      first_error = ST_OK;
   endtask

   task automatic push_result(logic [2:0] kind, logic [7:0] b, int number, int length,
                              logic [3:0] st);
      result_type r;
      r.kind = kind; r.byte_out = b; r.msg_type = hdr_type; r.token_count = hdr_tkl;
      r.class_bits = hdr_class; r.detail_bits = hdr_detail; r.message_id = hdr_id;
      r.option_number = number[15:0]; r.option_length = length[16:0];
      r.status = st; r.end_of_run = 0;
      word_results.push_back(r);
   endtask

   task automatic raise_error(logic [3:0] code);
      if (first_error == ST_OK) first_error = code;
      parse_phase = PH_HALT;
   endtask

   task automatic close_option();
      int sum;
      sum = prev_number + delta_acc;
      if (sum > 65535) begin
         raise_error(ST_OVERFLOW);
         return;
      end
      push_result(KIND_OPTION, 0, sum, length_acc, ST_OK);
      prev_number = sum[15:0];
      seen_option = 1;
      if (length_acc > 0) begin
         value_left = length_acc;
         parse_phase = PH_VALUE;
      end else
         parse_phase = PH_OPTHEAD;
   endtask

   task automatic open_length();
      if (length_acc == 13) begin
         ext_left = 1; parse_phase = PH_LENEXT;
      end else if (length_acc == 14) begin
         length_acc = 269; ext_left = 2; parse_phase = PH_LENEXT;
      end else
         close_option();
   endtask

   function automatic int add_extension(int acc, logic [7:0] b);
      return (ext_left == 2) ? acc + (int'(b) << 8) : acc + int'(b);
   endfunction

   task automatic parse_word(logic [7:0] b, logic last);
      logic [3:0] dn, ln, st;
      word_results.delete();
      case (parse_phase)
         PH_HEADER: begin
            if (hdr_index == 0) begin
               hdr_type = b[5:4];
               hdr_tkl = b[3:0];
               if (b[7:6] != cfg_version) raise_error(ST_VERSION);
               else if (hdr_tkl > cfg_max_tkl) raise_error(ST_TOKEN);
            end else if (hdr_index == 1) begin
               hdr_class = b[7:5];
               hdr_detail = b[4:0];
               if (!(hdr_class inside {3'd0, 3'd2, 3'd4, 3'd5})) raise_error(ST_CLASS);
            end else if (hdr_index == 2)
               hdr_id = {b, 8'h00};
            else begin
               hdr_id[7:0] = b;
               push_result(KIND_HEADER, 0, 0, 0, ST_OK);
               token_left = hdr_tkl;
               parse_phase = (token_left != 0) ? PH_TOKEN : PH_OPTHEAD;
            end
            hdr_index = hdr_index + 2'd1;
         end
         PH_TOKEN: begin
            push_result(KIND_TOKEN, b, 0, 0, ST_OK);
            token_left = token_left - 4'd1;
            if (token_left == 0) parse_phase = PH_OPTHEAD;
         end
         PH_OPTHEAD: begin
            dn = b[7:4];
            ln = b[3:0];
            if (b == 8'hff)
               parse_phase = PH_PAYLOAD;
            else if (dn == 15 || ln == 15)
               raise_error(ST_NIBBLE);
            else begin
               length_acc = ln;
               if (dn == 13) begin
                  delta_acc = 13; ext_left = 1; parse_phase = PH_DELTAEXT;
               end else if (dn == 14) begin
                  delta_acc = 269; ext_left = 2; parse_phase = PH_DELTAEXT;
               end else begin
                  delta_acc = dn;
                  open_length();
               end
            end
         end
         PH_DELTAEXT: begin
            delta_acc = add_extension(delta_acc, b);
            ext_left--;
            if (ext_left == 0) open_length();
         end
         PH_LENEXT: begin
            length_acc = add_extension(length_acc, b);
            ext_left--;
            if (ext_left == 0) close_option();
         end
         PH_VALUE: begin
            push_result(KIND_VALUE, b, 0, 0, ST_OK);
            value_left--;
            if (value_left == 0) parse_phase = PH_OPTHEAD;
         end
         PH_PAYLOAD: begin
            push_result(KIND_PAYLOAD, b, 0, 0, ST_OK);
            seen_payload = 1;
         end
         default: ;
      endcase
      if (last) begin
         st = ST_OK;
         if (first_error != ST_OK) st = first_error;
         else if (parse_phase == PH_PAYLOAD && !seen_payload) st = ST_EMPTY_PL;
         else if (parse_phase != PH_OPTHEAD && parse_phase != PH_PAYLOAD) st = ST_TRUNC;
         else if (hdr_class == 0 && hdr_detail == 0) begin
            if (hdr_type == TYPE_NON || hdr_tkl != 0 || seen_option || seen_payload)
               st = ST_BAD_EMPTY;
         end else if (hdr_type == TYPE_RST)
            st = ST_RESET_MSG;
         push_result(KIND_END, 0, 0, 0, st);
         clear_datagram();
      end
      if (word_results.size() > 0) word_results[word_results.size() - 1].end_of_run = 1;
      foreach (word_results[i]) expected_results.push_back(word_results[i]);
   endtask

   task automatic check_word(result_type got);
      result_type want;
      if (expected_results.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %p", got);
         return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.byte_out !== want.byte_out
          || got.msg_type !== want.msg_type || got.token_count !== want.token_count
          || got.class_bits !== want.class_bits || got.detail_bits !== want.detail_bits
          || got.message_id !== want.message_id
          || got.option_number !== want.option_number
          || got.option_length !== want.option_length || got.status !== want.status
          || got.end_of_run !== want.end_of_run) begin
         mismatches++;
         if (mismatches <= 10) $display("result mismatch\n  exp %p\n  got %p", want, got);
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         cfg_version <= 2'd1;
         cfg_max_tkl <= 4'd8;
         clear_datagram();
         expected_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_VERSION) cfg_version <= pwdata[1:0];
            else if (paddr == ADDR_MAX_TKL) cfg_max_tkl <= pwdata[3:0];
         end
         if (rsp_valid && rsp_ready) check_word(rsp_word);
         if (req_valid && req_ready) parse_word(req_data_byte, req_last_byte);
      end
   end

endmodule

// ===== bench/tb_coap_message_stream_parser.sv =====
`timescale 1ns / 1ps
// Testbench top for the CoAP message stream parser: clock, reset, CSR setup,
// datagram stimulus with idling and backpressure, and the verdict.
// Depends on cmsp_pkg, coap_message_stream_parser and cmsp_checker.
module tb_coap_message_stream_parser;
   import cmsp_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TARGET_WORDS   = 1450;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0, req_ready;
   logic [7:0]  req_data_byte = 0;
   logic        req_last_byte = 0;
   logic        rsp_valid, rsp_ready = 0;
   result_type  rsp_word;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = 0;
   logic [31:0] pwdata = 0, prdata;
   logic        pready;
   int          mismatches, pending;

   int          send_idle_pct = 0, stall_pct = 0;
   int          hold_asks = 0, hold_seen = 0, hold_left = 0;
   int          words_sent = 0, quiet_cycles = 0;
   logic [1:0]  cur_version = 1;
   logic [3:0]  cur_max_tkl = 8;
   logic [7:0]  datagram[$];

   always #6 clock = ~clock;

   coap_message_stream_parser i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_last_byte,
      .rsp_valid, .rsp_ready,
      .rsp_kind(rsp_word.kind), .rsp_byte_out(rsp_word.byte_out),
      .rsp_msg_type(rsp_word.msg_type), .rsp_token_count(rsp_word.token_count),
      .rsp_class_bits(rsp_word.class_bits), .rsp_detail_bits(rsp_word.detail_bits),
      .rsp_message_id(rsp_word.message_id), .rsp_option_number(rsp_word.option_number),
      .rsp_option_length(rsp_word.option_length), .rsp_status(rsp_word.status),
      .rsp_end_of_run(rsp_word.end_of_run),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   cmsp_checker i_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data_byte, .req_last_byte,
      .rsp_valid, .rsp_ready, .rsp_word, .psel, .penable, .pwrite, .paddr, .pwdata,
      .pready, .mismatches, .pending
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_seen != hold_asks) begin
         hold_seen <= hold_asks;
         hold_left <= 300;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_write(logic [0:0] index, logic [31:0] value);
      @(posedge clock);
      psel <= 1; pwrite <= 1; penable <= 0;
      paddr <= 3'(index) << 2; pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic send_datagram();
      foreach (datagram[i]) begin
         req_valid <= 1;
         req_data_byte <= datagram[i];
         req_last_byte <= (i == datagram.size() - 1);
         do @(posedge clock); while (!req_ready);
         words_sent++;
         if ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   task automatic add_extended(int field, bit is_delta);
      int n;
      n = datagram.size() - 1;
      if (field < 13) begin
         datagram[n] |= is_delta ? 8'(field << 4) : 8'(field);
      end else if (field < 269) begin
         datagram[n] |= is_delta ? 8'hd0 : 8'h0d;
         datagram.push_back(8'(field - 13));
      end else begin
         datagram[n] |= is_delta ? 8'he0 : 8'h0e;
         datagram.push_back(8'((field - 269) >> 8));
         datagram.push_back(8'(field - 269));
      end
   endtask

   task automatic build_datagram();
      int tkl, delta, len, pick, cls;
      datagram.delete();
      tkl = $urandom_range(cur_max_tkl);
      if ($urandom_range(19) == 0) tkl = $urandom_range(15);
      datagram.push_back({($urandom_range(19) == 0) ? 2'($urandom) : cur_version,
                          2'($urandom), 4'(tkl)});
      pick = $urandom_range(3);
      cls = (pick == 0) ? 0 : (pick == 1) ? 2 : (pick == 2) ? 4 : 5;
      if ($urandom_range(19) == 0) cls = $urandom_range(7);
      datagram.push_back({3'(cls), ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom)});
      datagram.push_back(8'($urandom));
      datagram.push_back(8'($urandom));
      repeat (tkl) datagram.push_back(8'($urandom));
      repeat ($urandom_range(3)) begin
         pick = $urandom_range(19);
         delta = (pick < 14) ? $urandom_range(12) : (pick < 18) ? $urandom_range(13, 268)
               : $urandom_range(269, 65804);
         pick = $urandom_range(19);
         len = (pick < 15) ? $urandom_range(6) : (pick < 19) ? $urandom_range(13, 24)
             : $urandom_range(269, 275);
         datagram.push_back(8'h00);
         add_extended(delta, 1);
         add_extended(len, 0);
         repeat (len) datagram.push_back(8'($urandom));
      end
      if ($urandom_range(2) != 0) begin
         datagram.push_back(8'hff);
         repeat ($urandom_range(0, 6)) datagram.push_back(8'($urandom));
      end
      pick = $urandom_range(19);
      if (pick == 0)
         datagram[$urandom_range(datagram.size() - 1)] = 8'($urandom);
      else if (pick == 1 && datagram.size() > 1)
         datagram = datagram[0:$urandom_range(datagram.size() - 2)];
      else if (pick == 2)
         datagram.push_back(8'($urandom));
   endtask

   task automatic send_bytes(logic [7:0] bytes[$]);
      datagram = bytes;
      send_datagram();
   endtask

   task automatic wait_drained();
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [1:0] versions[5] = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd1};
      logic [3:0] max_tkls[5] = '{4'd8, 4'd0, 4'd15, 4'd5, 4'd8};
      repeat (3) @(posedge clock);
      reset <= 0;
      for (int ph = 0; ph < 5; ph++) begin
         cur_version = versions[ph];
         cur_max_tkl = max_tkls[ph];
         csr_write(REG_VERSION, 32'(cur_version));
         csr_write(REG_MAX_TKL, 32'(cur_max_tkl));
         send_idle_pct = (ph % 4 == 1) ? 70 : (ph % 4 == 3) ? 28 : 0;
         stall_pct = (ph % 4 == 2) ? 70 : (ph % 4 == 3) ? 28 : 0;
         if (ph == 0) begin
            send_bytes('{8'h40, 8'h00, 8'h12, 8'h34});
            send_bytes('{8'h50, 8'h00, 8'h00, 8'h01});
            send_bytes('{8'h72, 8'h45, 8'hff, 8'hff, 8'haa, 8'h55});
            send_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'hd1, 8'hff, 8'h7e,
                         8'he0, 8'hff, 8'h00});
            send_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'h1d, 8'h00,
                         8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                         8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d, 8'hff});
            send_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'hf0});
            send_bytes('{8'h40, 8'h01, 8'h00, 8'h00, 8'h0f});
            send_bytes('{8'h80, 8'h01, 8'h00, 8'h00});
            send_bytes('{8'h4f, 8'h01, 8'h00, 8'h00});
            send_bytes('{8'h40, 8'h61, 8'h00, 8'h00});
            send_bytes('{8'h40, 8'h01, 8'h00});
            send_bytes('{8'h41, 8'h01, 8'h00, 8'h00, 8'h3c, 8'h9d, 8'h00});
            hold_asks++;
         end
         while (words_sent < TARGET_WORDS * (ph + 1) / 5) begin
            build_datagram();
            send_datagram();
         end
         req_valid <= 0;
         wait_drained();
      end
      if (mismatches == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

// ===== coap_message_stream_parser.f =====
hdl/cmsp_pkg.sv
hdl/cmsp_front.sv
hdl/cmsp_queue.sv
hdl/cmsp_back.sv
hdl/coap_message_stream_parser.sv
bench/cmsp_checker.sv
bench/tb_coap_message_stream_parser.sv
